>>> hdl/sds_pkg.sv
// Shared types and codes for the stream delimiter search core.
package sds_pkg;

    localparam logic [2:0] ACT_LOAD  = 3'd0;
    localparam logic [2:0] ACT_LEN   = 3'd1;
    localparam logic [2:0] ACT_DATA  = 3'd2;
    localparam logic [2:0] ACT_RESET = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_MATCH   = 2'd1;
    localparam logic [1:0] KIND_REFUSED = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_LEN,
        OP_DATA,
        OP_RESET,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       idx_ok;
        logic       len_sat;
        logic [5:0] idx;
        logic [7:0] data;
        logic [6:0] plen;
    } t_cmd;

endpackage

>>> hdl/stream_delimiter_search_core.sv
// Top level of the stream delimiter search core.
//
//   channel   direction  handshake                  payload
//   request   in         i_in_valid / o_in_ready    i_action, i_pattern_index,
//                                                   i_byte_value, i_pattern_length
//   result    out        o_out_valid / i_out_ready  o_kind, o_out_byte,
//                                                   o_matched_flag, o_last
//
// Control requests and refused bytes are handled from the idle state once the
// result register is free. A data byte is dequeued, then searched by a prefix
// compare loop (one compare per cycle on the dual-read pattern memory, holding
// on the final compare while the result register is full), then any bytes it
// releases pass through the result register, more of them with a longer held
// prefix on a mismatch.
// Reset is synchronous; the pattern memory is not cleared.
// A two-entry request queue lets intake run while the engine stalls on output.
module stream_delimiter_search_core #(
    parameter int MAX_PATTERN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_action,
    input  logic [5:0] i_pattern_index,
    input  logic [7:0] i_byte_value,
    input  logic [6:0] i_pattern_length,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_matched_flag,
    output logic       o_last
);
    import sds_pkg::*;

    t_cmd w_push_cmd;
    t_cmd w_pop_cmd;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    sds_front #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_front (
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_pattern_index  (i_pattern_index),
        .i_byte_value     (i_byte_value),
        .i_pattern_length (i_pattern_length),
        .i_q_full         (w_full),
        .o_push           (w_push),
        .o_cmd            (w_push_cmd)
    );

    sds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_pop_cmd)
    );

    sds_back #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (w_empty),
        .i_cmd          (w_pop_cmd),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_out_byte     (o_out_byte),
        .o_matched_flag (o_matched_flag),
        .o_last         (o_last)
    );

`ifndef SYNTH
    a_match_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_MATCH |-> o_matched_flag && o_last)
        else $error("match result without flag or last");

    a_refused_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_REFUSED |-> o_last)
        else $error("refused result not last");

    a_byte_only_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_BYTE |-> o_out_byte == 8'd0)
        else $error("non-release result carries a byte");

    a_release_unmatched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_BYTE |-> !o_matched_flag)
        else $error("byte released while matched");
`endif

endmodule

>>> hdl/sds_front.sv
// Request intake: decodes the action and range-checks index and length.
module sds_front #(
    parameter int MAX_PATTERN = 64
) (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_action,
    input  logic [5:0]        i_pattern_index,
    input  logic [7:0]        i_byte_value,
    input  logic [6:0]        i_pattern_length,
    input  logic              i_q_full,
    output logic              o_push,
    output sds_pkg::t_cmd     o_cmd
);
    import sds_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int CW = (LW > 7) ? LW : 7;

    t_op w_op;

    always_comb begin
        unique case (i_action)
            ACT_LOAD:  w_op = OP_LOAD;
            ACT_LEN:   w_op = OP_LEN;
            ACT_DATA:  w_op = OP_DATA;
            ACT_RESET: w_op = OP_RESET;
            ACT_CLEAR: w_op = OP_CLEAR;
            default:   w_op = OP_NOP;
        endcase
    end

    assign o_in_ready     = !i_q_full;
    assign o_push         = i_in_valid && !i_q_full;
    assign o_cmd.op       = w_op;
    assign o_cmd.idx_ok   = CW'(i_pattern_index) < CW'(MAX_PATTERN);
    assign o_cmd.len_sat  = CW'(i_pattern_length) > CW'(MAX_PATTERN);
    assign o_cmd.idx      = i_pattern_index;
    assign o_cmd.data     = i_byte_value;
    assign o_cmd.plen     = i_pattern_length;

endmodule

>>> hdl/sds_queue.sv
// Short request queue between intake and search engine.
module sds_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sds_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sds_pkg::t_cmd o_cmd
);
    import sds_pkg::*;

    localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [QA-1:0] r_wr;
    logic [QA-1:0] r_rd;
    logic [QA:0]   r_count;
    logic [QA-1:0] n_wr;
    logic [QA-1:0] n_rd;

    assign o_full  = r_count == (QA + 1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_slot[r_rd];
    assign n_wr    = (r_wr == QA'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QA'(1);
    assign n_rd    = (r_rd == QA'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QA'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QA + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QA + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

endmodule

>>> hdl/sds_back.sv
// Search engine: pattern memory, prefix compare loop, byte release and result register.
module sds_back #(
    parameter int MAX_PATTERN = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  sds_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [1:0]    o_kind,
    output logic [7:0]    o_out_byte,
    output logic          o_matched_flag,
    output logic          o_last
);
    import sds_pkg::*;

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int CW = (LW > 7) ? LW : 7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_REL
    } t_state;

    t_state        r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_mp, n_mp;
    logic [LW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_s, n_s;
    logic [LW-1:0] r_j, n_j;
    logic [LW-1:0] r_k, n_k;
    logic          r_matched, n_matched;
    logic [7:0]    r_data, n_data;

    logic          r_out_valid;
    logic [1:0]    r_kind;
    logic [7:0]    r_obyte;
    logic          r_omatch;
    logic          r_last;

    logic [7:0]    r_mem [MAX_PATTERN];
    logic [7:0]    r_rd_a;
    logic [7:0]    r_rd_b;

    logic          w_out_free;
    logic          w_emit;
    logic [1:0]    w_kind;
    logic [7:0]    w_byte;
    logic          w_last;
    logic          w_mem_we;
    logic [CW-1:0] w_idx_ext;
    logic [AW-1:0] w_waddr;
    logic [LW-1:0] w_addr_b_full;
    logic [AW-1:0] w_addr_a;
    logic [AW-1:0] w_addr_b;
    logic [LW-1:0] w_pos;
    logic [LW-1:0] w_j_inc;
    logic [LW-1:0] w_k_inc;
    logic [7:0]    w_win;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_pos      = r_s + r_j;
    assign w_j_inc    = r_j + LW'(1);
    assign w_k_inc    = r_k + LW'(1);
    assign w_win      = (w_pos == r_cur) ? r_data : r_rd_b;
    assign w_idx_ext  = CW'(i_cmd.idx);
    assign w_waddr    = w_idx_ext[AW-1:0];
    assign w_mem_we   = o_pop && (i_cmd.op == OP_LOAD) && i_cmd.idx_ok;

    assign w_addr_b_full = (n_state == S_REL) ? n_k : n_s + n_j;
    assign w_addr_a      = n_j[AW-1:0];
    assign w_addr_b      = w_addr_b_full[AW-1:0];

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_mp      = r_mp;
        n_cur     = r_cur;
        n_s       = r_s;
        n_j       = r_j;
        n_k       = r_k;
        n_matched = r_matched;
        n_data    = r_data;
        w_emit    = 1'b0;
        w_kind    = KIND_NONE;
        w_byte    = 8'd0;
        w_last    = 1'b1;
        o_pop     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    if (i_cmd.op == OP_DATA && !r_matched && r_len != '0) begin
                        o_pop   = 1'b1;
                        n_data  = i_cmd.data;
                        n_cur   = (r_mp >= r_len) ? '0 : r_mp;
                        n_s     = '0;
                        n_j     = '0;
                        n_state = S_CMP;
                    end else if (w_out_free) begin
                        o_pop  = 1'b1;
                        w_emit = 1'b1;
                        unique case (i_cmd.op)
                            OP_LOAD: begin
                                n_mp      = '0;
                                n_matched = 1'b0;
                            end
                            OP_LEN: begin
                                n_len     = i_cmd.len_sat ? LW'(MAX_PATTERN)
                                                          : LW'(i_cmd.plen);
                                n_mp      = '0;
                                n_matched = 1'b0;
                            end
                            OP_DATA: begin
                                w_kind = KIND_REFUSED;
                            end
                            OP_RESET: begin
                                n_mp      = '0;
                                n_matched = 1'b0;
                            end
                            OP_CLEAR: begin
                                n_matched = 1'b0;
                            end
                            default: begin
                                n_mp = r_mp;
                            end
                        endcase
                    end
                end
            end
            S_CMP: begin
                if (w_win == r_rd_a) begin
                    if (w_pos == r_cur) begin
                        if (w_j_inc == r_len) begin
                            if (w_out_free) begin
                                w_emit    = 1'b1;
                                w_kind    = KIND_MATCH;
                                n_matched = 1'b1;
                                n_mp      = '0;
                                n_state   = S_IDLE;
                            end
                        end else if (r_s == '0) begin
                            if (w_out_free) begin
                                w_emit  = 1'b1;
                                n_mp    = w_j_inc;
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_mp    = w_j_inc;
                            n_k     = '0;
                            n_state = S_REL;
                        end
                    end else begin
                        n_j = w_j_inc;
                    end
                end else if (r_s == r_cur) begin
                    n_s     = r_s + LW'(1);
                    n_mp    = '0;
                    n_k     = '0;
                    n_state = S_REL;
                end else begin
                    n_s = r_s + LW'(1);
                    n_j = '0;
                end
            end
            S_REL: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    w_kind = KIND_BYTE;
                    w_byte = (r_k == r_cur) ? r_data : r_rd_b;
                    w_last = w_k_inc == r_s;
                    n_k    = w_k_inc;
                    if (w_k_inc == r_s) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_mp        <= '0;
            r_matched   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_mp      <= n_mp;
            r_matched <= n_matched;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_cur  <= n_cur;
        r_s    <= n_s;
        r_j    <= n_j;
        r_k    <= n_k;
        r_data <= n_data;
        if (w_emit) begin
            r_kind   <= w_kind;
            r_obyte  <= w_byte;
            r_omatch <= n_matched;
            r_last   <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_waddr] <= i_cmd.data;
        end
        r_rd_a <= r_mem[w_addr_a];
        r_rd_b <= r_mem[w_addr_b];
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_out_byte     = r_obyte;
    assign o_matched_flag = r_omatch;
    assign o_last         = r_last;

endmodule
